// File: rtl/signed_decimal_field_formatter_macros.svh
// Assertion macros shared by the formatter RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside of reset.
`define SDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SDF_ASSERT(lbl, prop, msg)

`define SDF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/sdf_pkg.sv
package sdf_pkg;

  // Default bound on field width
  localparam int MAX_FIELD_DEF = 64;

  // Largest number of decimal digits in a 32-bit magnitude
  localparam int NUM_DIGITS = 10;

  // Reciprocal of ten, scaled by 2^35, for the digit divider
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  // ASCII characters of the field
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Field segments, in output order
  localparam int NUM_PHASES = 6;
  typedef logic [2:0] phase_t;
  localparam phase_t PH_LPAD = 3'd0;
  localparam phase_t PH_SIGN = 3'd1;
  localparam phase_t PH_ZPAD = 3'd2;
  localparam phase_t PH_PREC = 3'd3;
  localparam phase_t PH_DIG  = 3'd4;
  localparam phase_t PH_RPAD = 3'd5;

endpackage

// File: rtl/signed_decimal_field_formatter.sv
// Signed decimal field formatter: the printf %d conversion in hardware.
// Input: pulse start with in_value and the spec (in_force_plus, in_space_sign,
// in_zero_pad, in_left_align, in_has_precision, in_precision, in_min_width);
// the request is taken at a rising edge where start is high and busy is low.
// Output: one ASCII character per cycle on out_char, marked by out_valid,
// with out_last on the final one. The receiver cannot stall: every strobe
// is a character taken. A field of length zero gives no strobe at all.
// Flow: the magnitude goes through one shared divide-by-ten unit (a 32x32
// reciprocal multiply), one digit per cycle, 1..10 digits (none when
// precision zero meets value zero). A layout state then sets the segment
// lengths, and the field is sent at one character per cycle. busy drops
// while the last character is shown, so the next request may be taken then.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; a request in progress is abandoned.

`include "signed_decimal_field_formatter_macros.svh"

module signed_decimal_field_formatter
  import sdf_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  input  logic        in_zero_pad,
  input  logic        in_left_align,
  input  logic        in_has_precision,
  input  logic [5:0]  in_precision,
  input  logic [6:0]  in_min_width,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_last
);

  localparam int CW = $clog2(MAX_FIELD + 1);
  localparam int DW = $clog2(NUM_DIGITS + 1);
  localparam int IW = $clog2(NUM_DIGITS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIGIT  = 2'd1;
  localparam logic [1:0] ST_LAYOUT = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  typedef logic [CW-1:0] cnt_t;

  // Control state
  logic [1:0]  state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  cnt_t        cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Payload state
  logic [31:0] mag_r, mag_nxt;
  logic [3:0]  digs_r [NUM_DIGITS];
  logic [3:0]  digs_nxt [NUM_DIGITS];
  logic [DW-1:0] ndig_r, ndig_nxt;
  logic [7:0]  sign_ch_r, sign_ch_nxt;
  logic        nsign_r, nsign_nxt;
  logic        left_r, left_nxt;
  logic        zero_eff_r, zero_eff_nxt;
  cnt_t        width_r, width_nxt;
  cnt_t        prec_r, prec_nxt;
  cnt_t        len_r [NUM_PHASES];
  cnt_t        len_nxt [NUM_PHASES];
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  // Shared divider and layout signals
  logic [63:0] prod;
  logic [28:0] quot;
  logic [3:0]  q10_lo;
  logic [3:0]  rem;
  logic        accept;
  logic [6:0]  prec_in;
  cnt_t        ndig_w;
  cnt_t        nprec;
  cnt_t        used;
  cnt_t        npad;
  cnt_t        cnt_m1;
  cnt_t        lay_len [NUM_PHASES];
  logic [NUM_PHASES-1:0] lay_mask;
  logic [NUM_PHASES-1:0] run_mask;
  logic        lay_found, run_found;
  phase_t      lay_first, run_next;
  logic [7:0]  emit_ch;

  // Find the first nonempty segment at or above a start code
  function automatic logic [3:0] find_from(input logic [NUM_PHASES-1:0] mask,
                                           input phase_t from);
    logic   found;
    phase_t idx;
    found = 1'b0;
    idx   = PH_LPAD;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (!found && mask[p] && (3'(p) >= from)) begin
        found = 1'b1;
        idx   = 3'(p);
      end
    end
    return {found, idx};
  endfunction

  assign accept = start && (state_r == ST_IDLE);

  // Divide the magnitude by ten: quotient by reciprocal, remainder in 4 bits
  assign prod   = 64'(mag_r) * 64'(RECIP_10);
  assign quot   = prod[63:RECIP_SHIFT];
  assign q10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign rem    = mag_r[3:0] - q10_lo;

  // Segment lengths from the digit count and the spec
  always_comb begin
    ndig_w = CW'(ndig_r);
    nprec  = (prec_r > ndig_w) ? (prec_r - ndig_w) : '0;
    used   = CW'(nsign_r) + nprec + ndig_w;
    npad   = (width_r > used) ? (width_r - used) : '0;
    lay_len[PH_LPAD] = (!left_r && !zero_eff_r) ? npad : '0;
    lay_len[PH_SIGN] = CW'(nsign_r);
    lay_len[PH_ZPAD] = zero_eff_r ? npad : '0;
    lay_len[PH_PREC] = nprec;
    lay_len[PH_DIG]  = ndig_w;
    lay_len[PH_RPAD] = left_r ? npad : '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      lay_mask[p] = (lay_len[p] != '0);
      run_mask[p] = (len_r[p] != '0);
    end
    {lay_found, lay_first} = find_from(lay_mask, PH_LPAD);
    if (phase_r == PH_RPAD) begin
      run_found = 1'b0;
      run_next  = PH_LPAD;
    end else begin
      {run_found, run_next} = find_from(run_mask, phase_r + 3'd1);
    end
  end

  // Pick the character of the current segment
  always_comb begin
    cnt_m1 = cnt_r - cnt_t'(1);
    case (phase_r)
      PH_LPAD: emit_ch = CH_SPACE;
      PH_SIGN: emit_ch = sign_ch_r;
      PH_ZPAD: emit_ch = CH_ZERO;
      PH_PREC: emit_ch = CH_ZERO;
      PH_DIG: begin
        if (cnt_m1 < cnt_t'(NUM_DIGITS)) begin
          emit_ch = CH_ZERO + {4'b0000, digs_r[cnt_m1[IW-1:0]]};
        end else begin
          emit_ch = CH_ZERO;
        end
      end
      PH_RPAD: emit_ch = CH_SPACE;
      default: emit_ch = CH_SPACE;
    endcase
  end

  // Sequencer: latch, divide, lay out, emit
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    mag_nxt       = mag_r;
    digs_nxt      = digs_r;
    ndig_nxt      = ndig_r;
    sign_ch_nxt   = sign_ch_r;
    nsign_nxt     = nsign_r;
    left_nxt      = left_r;
    zero_eff_nxt  = zero_eff_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    len_nxt       = len_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    prec_in       = {1'b0, in_precision};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mag_nxt  = in_value[31] ? (32'd0 - in_value) : in_value;
          ndig_nxt = '0;
          if (in_value[31]) begin
            sign_ch_nxt = CH_MINUS;
          end else if (in_force_plus) begin
            sign_ch_nxt = CH_PLUS;
          end else begin
            sign_ch_nxt = CH_SPACE;
          end
          nsign_nxt    = in_value[31] || in_force_plus || in_space_sign;
          left_nxt     = in_left_align;
          zero_eff_nxt = in_zero_pad && !in_left_align && !in_has_precision;
          width_nxt    = (in_min_width > 7'(MAX_FIELD)) ? cnt_t'(MAX_FIELD)
                                                        : cnt_t'(in_min_width);
          if (!in_has_precision) begin
            prec_nxt = '0;
          end else if (prec_in > 7'(MAX_FIELD - 1)) begin
            prec_nxt = cnt_t'(MAX_FIELD - 1);
          end else begin
            prec_nxt = cnt_t'(prec_in);
          end
          // Drop all digits for precision zero with value zero
          if (in_has_precision && (in_precision == 6'd0) && (in_value == 32'd0)) begin
            state_nxt = ST_LAYOUT;
          end else begin
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        digs_nxt[ndig_r[IW-1:0]] = rem;
        ndig_nxt = ndig_r + DW'(1);
        mag_nxt  = {3'b000, quot};
        if ((quot == '0) || (ndig_r == DW'(NUM_DIGITS - 1))) begin
          state_nxt = ST_LAYOUT;
        end
      end
      ST_LAYOUT: begin
        len_nxt   = lay_len;
        phase_nxt = lay_first;
        cnt_nxt   = lay_len[lay_first];
        state_nxt = lay_found ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = emit_ch;
        out_last_nxt  = (cnt_r == cnt_t'(1)) && !run_found;
        if (cnt_r == cnt_t'(1)) begin
          if (run_found) begin
            phase_nxt = run_next;
            cnt_nxt   = len_r[run_next];
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_LPAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    digs_r     <= digs_nxt;
    ndig_r     <= ndig_nxt;
    sign_ch_r  <= sign_ch_nxt;
    nsign_r    <= nsign_nxt;
    left_r     <= left_nxt;
    zero_eff_r <= zero_eff_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    len_r      <= len_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `SDF_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `SDF_ASSERT(a_strobe_from_emit, out_valid |-> $past(state_r == ST_EMIT), "strobe outside emission")
  `SDF_ASSERT(a_last_ends_field, (out_valid && out_last) |=> !out_valid, "character after last")
  `SDF_ASSERT(a_emit_count, (state_r == ST_EMIT) |-> (cnt_r != '0), "empty segment in emission")
  `SDF_ASSERT(a_digit_bound, (state_r == ST_DIGIT) |-> (ndig_r < DW'(NUM_DIGITS)), "too many digits")
  `SDF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy && !out_valid), "reset left block active")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sdf_pkg::*;

  localparam int FIELD_LIMIT = MAX_FIELD_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_PER_PHASE = 100;

  // One conversion request: value plus printf-style spec
  typedef struct {
    logic [31:0] value;
    logic        force_plus;
    logic        space_sign;
    logic        zero_pad;
    logic        left_align;
    logic        has_precision;
    logic [5:0]  precision;
    logic [6:0]  min_width;
  } spec_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  // Expected characters of every accepted request, oldest first
  class field_scoreboard;
    field_char_t pending_chars[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // Lay out the formatted field of one request and queue its characters
    function void note_request(spec_t s);
      logic       neg;
      logic       zero_eff;
      logic [31:0] mag;
      logic [31:0] rem;
      logic [7:0] sign_ch;
      logic [7:0] pad_ch;
      logic [7:0] digs[10];
      logic [7:0] field[$];
      int         ndig;
      int         nsign;
      int         nprec;
      int         npad;
      int         used;
      int         total;
      int         prec;
      int         width;
      field_char_t fc;
      neg = s.value[31];
      mag = neg ? (~s.value + 32'd1) : s.value;
      prec = s.has_precision ? int'(s.precision) : 0;
      width = int'(s.min_width);
      if (width > FIELD_LIMIT) width = FIELD_LIMIT;
      if (prec > FIELD_LIMIT - 1) prec = FIELD_LIMIT - 1;

      // Digits, least significant first; none for zero at precision zero
      ndig = 0;
      if (!(s.has_precision && prec == 0 && mag == 32'd0)) begin
        rem = mag;
        do begin
          digs[ndig] = CH_ZERO + 8'(rem % 32'd10);
          ndig++;
          rem = rem / 32'd10;
        end while (rem != 32'd0 && ndig < 10);
      end

      if (neg) sign_ch = CH_MINUS;
      else if (s.force_plus) sign_ch = CH_PLUS;
      else if (s.space_sign) sign_ch = CH_SPACE;
      else sign_ch = 8'h00;
      nsign = (sign_ch != 8'h00) ? 1 : 0;

      nprec = (prec > ndig) ? prec - ndig : 0;
      used = nsign + nprec + ndig;
      npad = (width > used) ? width - used : 0;
      total = used + npad;
      if (total > FIELD_LIMIT) total = FIELD_LIMIT;

      // Left align wins over zero padding; precision also disables it
      zero_eff = s.zero_pad && !s.left_align && !s.has_precision;
      pad_ch = zero_eff ? CH_ZERO : CH_SPACE;

      if (!s.left_align && !zero_eff)
        for (int i = 0; i < npad && field.size() < total; i++) field.push_back(pad_ch);
      if (nsign != 0 && field.size() < total) field.push_back(sign_ch);
      if (zero_eff)
        for (int i = 0; i < npad && field.size() < total; i++) field.push_back(pad_ch);
      for (int i = 0; i < nprec && field.size() < total; i++) field.push_back(CH_ZERO);
      for (int i = ndig; i > 0 && field.size() < total; i--) field.push_back(digs[i - 1]);
      if (s.left_align)
        for (int i = 0; i < npad && field.size() < total; i++) field.push_back(pad_ch);

      foreach (field[i]) begin
        fc.ch = field[i];
        fc.last = (i == field.size() - 1);
        pending_chars.push_back(fc);
      end
    endfunction

    // Compare one output character with the oldest expectation
    function void check_char(logic [7:0] ch, logic last);
      field_char_t exp_fc;
      if (pending_chars.size() == 0) begin
        $error("out_char: no character expected, actual %h", ch);
        errors++;
      end else begin
        exp_fc = pending_chars.pop_front();
        if (ch !== exp_fc.ch) begin
          $error("out_char: expected %h, actual %h", exp_fc.ch, ch);
          errors++;
        end
        if (last !== exp_fc.last) begin
          $error("out_last: expected %b, actual %b", exp_fc.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_value = '0;
  logic        in_force_plus = 1'b0;
  logic        in_space_sign = 1'b0;
  logic        in_zero_pad = 1'b0;
  logic        in_left_align = 1'b0;
  logic        in_has_precision = 1'b0;
  logic [5:0]  in_precision = '0;
  logic [6:0]  in_min_width = '0;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;

  int              cycle_count = 0;
  field_scoreboard board;

  signed_decimal_field_formatter #(
    .MAX_FIELD(FIELD_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .in_force_plus(in_force_plus),
    .in_space_sign(in_space_sign),
    .in_zero_pad(in_zero_pad),
    .in_left_align(in_left_align),
    .in_has_precision(in_has_precision),
    .in_precision(in_precision),
    .in_min_width(in_min_width),
    .out_valid(out_valid),
    .out_char(out_char),
    .out_last(out_last)
  );

  always #10 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Note accepted requests and check every strobed character
  always @(posedge clk) begin
    spec_t taken;
    if (rst_n) begin
      if (start && !busy) begin
        taken.value = in_value;
        taken.force_plus = in_force_plus;
        taken.space_sign = in_space_sign;
        taken.zero_pad = in_zero_pad;
        taken.left_align = in_left_align;
        taken.has_precision = in_has_precision;
        taken.precision = in_precision;
        taken.min_width = in_min_width;
        board.note_request(taken);
      end
      if (out_valid !== 1'b0) board.check_char(out_char, out_last);
    end
  end

  function automatic spec_t make_spec(logic [31:0] value, logic plus, logic spc, logic zpad,
                                      logic left, logic hasp, logic [5:0] prec,
                                      logic [6:0] width);
    spec_t s;
    s.value = value;
    s.force_plus = plus;
    s.space_sign = spc;
    s.zero_pad = zpad;
    s.left_align = left;
    s.has_precision = hasp;
    s.precision = prec;
    s.min_width = width;
    return s;
  endfunction

  // Mostly short fields, a few near the width bound
  function automatic spec_t random_spec();
    spec_t s;
    case ($urandom_range(4))
      0: s.value = $urandom_range(20);
      1: s.value = 32'd0 - 32'($urandom_range(999));
      2: begin
        case ($urandom_range(3))
          0: s.value = 32'h8000_0000;
          1: s.value = 32'h7fff_ffff;
          2: s.value = 32'h0;
          default: s.value = 32'hffff_ffff;
        endcase
      end
      default: s.value = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(3) == 0) s.value = $urandom;
    s.force_plus = 1'($urandom_range(1));
    s.space_sign = 1'($urandom_range(1));
    s.zero_pad = 1'($urandom_range(1));
    s.left_align = 1'($urandom_range(1));
    s.has_precision = 1'($urandom_range(1));
    s.precision = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
    s.min_width = ($urandom_range(4) == 0) ? 7'($urandom_range(64)) : 7'($urandom_range(20));
    return s;
  endfunction

  // Hold off at random, then present one request until it is taken
  task automatic send_request(input spec_t s, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_value <= s.value;
    in_force_plus <= s.force_plus;
    in_space_sign <= s.space_sign;
    in_zero_pad <= s.zero_pad;
    in_left_align <= s.left_align;
    in_has_precision <= s.has_precision;
    in_precision <= s.precision;
    in_min_width <= s.min_width;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int phase_idle[3];
    board = new();
    phase_idle[0] = 22;
    phase_idle[1] = 87;
    phase_idle[2] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, sign rules, padding rules, empty field
    send_request(make_spec(32'd0, 0, 0, 0, 0, 0, 6'd0, 7'd0), 22);
    send_request(make_spec(32'd0, 0, 0, 0, 0, 1, 6'd0, 7'd0), 22);
    send_request(make_spec(32'd0, 1, 0, 0, 0, 1, 6'd0, 7'd5), 22);
    send_request(make_spec(32'd0, 0, 0, 0, 1, 1, 6'd0, 7'd4), 22);
    send_request(make_spec(32'd0, 0, 0, 0, 0, 1, 6'd1, 7'd0), 22);
    send_request(make_spec(32'h8000_0000, 0, 0, 0, 0, 0, 6'd0, 7'd0), 22);
    send_request(make_spec(32'h7fff_ffff, 1, 0, 0, 0, 0, 6'd0, 7'd0), 22);
    send_request(make_spec(32'hffff_ffff, 0, 0, 1, 0, 0, 6'd0, 7'd8), 22);
    send_request(make_spec(32'd42, 0, 1, 1, 0, 0, 6'd0, 7'd6), 22);
    send_request(make_spec(32'd42, 0, 0, 1, 1, 0, 6'd0, 7'd6), 22);
    send_request(make_spec(32'd42, 0, 0, 1, 0, 1, 6'd4, 7'd8), 22);
    send_request(make_spec(32'd7, 1, 0, 0, 0, 1, 6'd63, 7'd64), 22);
    send_request(make_spec(32'hffff_fffb, 0, 0, 0, 1, 1, 6'd63, 7'd64), 22);
    send_request(make_spec(32'd123, 0, 0, 0, 1, 0, 6'd0, 7'd64), 22);
    send_request(make_spec(32'hffff_ff85, 0, 0, 1, 0, 0, 6'd0, 7'd64), 22);
    send_request(make_spec(32'd0, 0, 0, 0, 0, 0, 6'd10, 7'd3), 22);
    send_request(make_spec(32'd1_000_000_000, 0, 1, 0, 0, 0, 6'd0, 7'd0), 22);
    send_request(make_spec(32'hffff_fc19, 0, 0, 0, 0, 1, 6'd2, 7'd1), 22);
    send_request(make_spec(32'd5, 1, 1, 0, 0, 0, 6'd0, 7'd3), 22);
    send_request(make_spec(32'h8000_0000, 1, 1, 1, 0, 0, 6'd0, 7'd64), 22);
    send_request(make_spec(32'd9, 0, 1, 1, 1, 1, 6'd33, 7'd50), 22);

    // Random: sender idles sometimes, then often, then never
    for (int p = 0; p < 3; p++)
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_request(random_spec(), phase_idle[p]);
    start <= 1'b0;

    // Drain outstanding characters, then let the block settle
    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
